>>> hw/rtl/rbms_pkg.sv
// Shared types, constants and helpers for the rigid body motion step block.
`default_nettype none

package rbms_pkg;

    // Field widths fixed by the data formats
    localparam int FIELD_W   = 32;
    localparam int DT_W      = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [FIELD_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [FIELD_W-1:0] S32_MIN = 32'sh8000_0000;

    // Register reset values
    localparam logic signed [FIELD_W-1:0] GRAV_X_RST = 32'sd0;
    localparam logic signed [FIELD_W-1:0] GRAV_Y_RST = -32'sd642253;
    localparam logic signed [FIELD_W-1:0] GRAV_Z_RST = 32'sd0;
    localparam logic [DT_W-1:0]           DT_RST     = 16'd1092;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAV_X    = 2'd0,
        CFG_GRAV_Y    = 2'd1,
        CFG_GRAV_Z    = 2'd2,
        CFG_TIME_STEP = 2'd3
    } t_cfg_idx;

    // One body as it arrives
    typedef struct packed {
        logic signed [FIELD_W-1:0] force_x;
        logic signed [FIELD_W-1:0] force_y;
        logic signed [FIELD_W-1:0] force_z;
        logic        [FIELD_W-1:0] mass;
        logic signed [FIELD_W-1:0] vel_x;
        logic signed [FIELD_W-1:0] vel_y;
        logic signed [FIELD_W-1:0] vel_z;
        logic signed [FIELD_W-1:0] pos_x;
        logic signed [FIELD_W-1:0] pos_y;
        logic signed [FIELD_W-1:0] pos_z;
        logic                      use_gravity;
        logic                      active;
    } t_body_in;

    // One integrated body
    typedef struct packed {
        logic signed [FIELD_W-1:0] new_pos_x;
        logic signed [FIELD_W-1:0] new_pos_y;
        logic signed [FIELD_W-1:0] new_pos_z;
        logic signed [FIELD_W-1:0] new_vel_x;
        logic signed [FIELD_W-1:0] new_vel_y;
        logic signed [FIELD_W-1:0] new_vel_z;
        logic signed [FIELD_W-1:0] accel_x;
        logic signed [FIELD_W-1:0] accel_y;
        logic signed [FIELD_W-1:0] accel_z;
        logic                      updated;
        logic                      zero_mass_error;
    } t_body_out;

    // Clamp a 35-bit signed value to the signed 32-bit range
    function automatic logic signed [FIELD_W-1:0] sat32(input logic signed [34:0] v);
        logic signed [FIELD_W-1:0] res;
        if (v > 35'(S32_MAX)) begin
            res = S32_MAX;
        end else if (v < 35'(S32_MIN)) begin
            res = S32_MIN;
        end else begin
            res = v[FIELD_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rbms_div.sv
// Pipelined restoring divider: one quotient bit per stage, side data carried along.
`default_nettype none

module rbms_div
    import rbms_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 1
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic [FIELD_W-1:0]             i_mag,
    input  wire logic [FIELD_W-1:0]             i_den,
    input  wire logic [SIDE_W-1:0]              i_side,
    output logic      [FIELD_W+FRAC_BITS-1:0]   o_quo,
    output logic      [SIDE_W-1:0]              o_side
);

    localparam int DW = FIELD_W + FRAC_BITS;

    // Partial remainder and divisor are not needed past the last stage
    logic [FIELD_W-1:0] r_rem  [DW-1];
    logic [FIELD_W-1:0] r_den  [DW-1];
    logic [DW-1:0]      r_q    [DW];
    logic [SIDE_W-1:0]  r_side [DW];

    for (genvar j = 0; j < DW; j++) begin : g_stage
        logic [FIELD_W-1:0] w_rem;
        logic [FIELD_W-1:0] w_den;
        logic [DW-1:0]      w_q;
        logic [SIDE_W-1:0]  w_side;
        logic [FIELD_W:0]   w_trial;
        logic               w_ge;

        if (j == 0) begin : g_first
            assign w_rem  = '0;
            assign w_den  = i_den;
            assign w_q    = {i_mag, {FRAC_BITS{1'b0}}};
            assign w_side = i_side;
        end else begin : g_next
            assign w_rem  = r_rem[j-1];
            assign w_den  = r_den[j-1];
            assign w_q    = r_q[j-1];
            assign w_side = r_side[j-1];
        end

        // shift in next dividend bit, try the subtract
        assign w_trial = {w_rem, w_q[DW-1]};
        assign w_ge    = w_trial >= {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[j]    <= {w_q[DW-2:0], w_ge};
                r_side[j] <= w_side;
            end
        end

        if (j < DW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[j] <= w_den;
                    r_rem[j] <= w_ge ? FIELD_W'(w_trial - {1'b0, w_den})
                                     : w_trial[FIELD_W-1:0];
                end
            end
        end
    end

    assign o_quo  = r_q[DW-1];
    assign o_side = r_side[DW-1];

endmodule

`default_nettype wire

>>> hw/rtl/rbms_lane.sv
// One axis lane: force over mass, gravity, displacement and velocity update.
`default_nettype none

module rbms_lane
    import rbms_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic signed [FIELD_W-1:0]  i_force,
    input  wire logic        [FIELD_W-1:0]  i_mass,
    input  wire logic signed [FIELD_W-1:0]  i_vel,
    input  wire logic signed [FIELD_W-1:0]  i_pos,
    input  wire logic                       i_use_gravity,
    input  wire logic                       i_active,
    input  wire logic signed [FIELD_W-1:0]  i_grav,
    input  wire logic        [DT_W-1:0]     i_dt,
    input  wire logic        [DT_W-1:0]     i_dtsq,
    output logic signed [FIELD_W-1:0]       o_new_pos,
    output logic signed [FIELD_W-1:0]       o_new_vel,
    output logic signed [FIELD_W-1:0]       o_accel
);

    localparam int DW     = FIELD_W + FRAC_BITS;
    localparam int SIDE_W = 2 * FIELD_W + 5;
    localparam int HALF17 = 65536;
    localparam int HALF16 = 32768;

    // ---- entry: magnitude and flags
    logic [FIELD_W-1:0]        r0_mag;
    logic [FIELD_W-1:0]        r0_mass;
    logic signed [FIELD_W-1:0] r0_vel;
    logic signed [FIELD_W-1:0] r0_pos;
    logic                      r0_neg;
    logic                      r0_mzero;
    logic                      r0_fzero;
    logic                      r0_useg;
    logic                      r0_act;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_mag   <= i_force[FIELD_W-1] ? FIELD_W'(-i_force) : FIELD_W'(i_force);
            r0_mass  <= i_mass;
            r0_vel   <= i_vel;
            r0_pos   <= i_pos;
            r0_neg   <= i_force[FIELD_W-1];
            r0_mzero <= (i_mass == '0);
            r0_fzero <= (i_force == '0);
            r0_useg  <= i_use_gravity;
            r0_act   <= i_active;
        end
    end

    // ---- divider
    logic [DW-1:0]     w_quo;
    logic [SIDE_W-1:0] w_side;

    rbms_div #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_mag  (r0_mag),
        .i_den  (r0_mass),
        .i_side ({r0_vel, r0_pos, r0_useg, r0_act, r0_neg, r0_mzero, r0_fzero}),
        .o_quo  (w_quo),
        .o_side (w_side)
    );

    logic signed [FIELD_W-1:0] d_vel;
    logic signed [FIELD_W-1:0] d_pos;
    logic                      d_useg;
    logic                      d_act;
    logic                      d_neg;
    logic                      d_mzero;
    logic                      d_fzero;

    assign {d_vel, d_pos, d_useg, d_act, d_neg, d_mzero, d_fzero} = w_side;

    // ---- quotient to signed force/mass with saturation
    logic                      w_hi;
    logic signed [FIELD_W-1:0] n1_f;
    logic signed [FIELD_W-1:0] r1_f;
    logic signed [FIELD_W-1:0] r1_vel;
    logic signed [FIELD_W-1:0] r1_pos;
    logic                      r1_useg;
    logic                      r1_act;

    assign w_hi = |w_quo[DW-1:FIELD_W];

    always_comb begin
        if (d_mzero) begin
            n1_f = d_fzero ? '0 : (d_neg ? S32_MIN : S32_MAX);
        end else if (d_neg) begin
            n1_f = (w_hi || (w_quo[FIELD_W-1] && (|w_quo[FIELD_W-2:0]))) ? S32_MIN
                 : FIELD_W'(33'sd0 - $signed({1'b0, w_quo[FIELD_W-1:0]}));
        end else begin
            n1_f = (w_hi || w_quo[FIELD_W-1]) ? S32_MAX : $signed(w_quo[FIELD_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_f    <= n1_f;
            r1_vel  <= d_vel;
            r1_pos  <= d_pos;
            r1_useg <= d_useg;
            r1_act  <= d_act;
        end
    end

    // ---- add gravity
    logic signed [FIELD_W-1:0] r2_a;
    logic signed [FIELD_W-1:0] r2_f;
    logic signed [FIELD_W-1:0] r2_vel;
    logic signed [FIELD_W-1:0] r2_pos;
    logic                      r2_act;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_a   <= r1_useg ? sat32(35'(r1_f) + 35'(i_grav)) : r1_f;
            r2_f   <= r1_f;
            r2_vel <= r1_vel;
            r2_pos <= r1_pos;
            r2_act <= r1_act;
        end
    end

    // ---- products: a*dt^2, v*dt, a*dt
    logic signed [48:0]        w_pa2;
    logic signed [48:0]        w_pv;
    logic signed [48:0]        w_pad;
    logic signed [47:0]        r3_pa2;
    logic signed [47:0]        r3_pv;
    logic signed [47:0]        r3_pad;
    logic signed [FIELD_W-1:0] r3_f;
    logic signed [FIELD_W-1:0] r3_vel;
    logic signed [FIELD_W-1:0] r3_pos;
    logic                      r3_act;

    assign w_pa2 = r2_a   * $signed({1'b0, i_dtsq});
    assign w_pv  = r2_vel * $signed({1'b0, i_dt});
    assign w_pad = r2_a   * $signed({1'b0, i_dt});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_pa2 <= w_pa2[47:0];
            r3_pv  <= w_pv[47:0];
            r3_pad <= w_pad[47:0];
            r3_f   <= r2_f;
            r3_vel <= r2_vel;
            r3_pos <= r2_pos;
            r3_act <= r2_act;
        end
    end

    // ---- displacement sum 2*v*dt + a*dt^2
    logic signed [49:0]        r4_sd;
    logic signed [47:0]        r4_pad;
    logic signed [FIELD_W-1:0] r4_f;
    logic signed [FIELD_W-1:0] r4_vel;
    logic signed [FIELD_W-1:0] r4_pos;
    logic                      r4_act;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_sd  <= $signed({r3_pv[47], r3_pv, 1'b0}) + 50'(r3_pa2);
            r4_pad <= r3_pad;
            r4_f   <= r3_f;
            r4_vel <= r3_vel;
            r4_pos <= r3_pos;
            r4_act <= r3_act;
        end
    end

    // ---- round to nearest, ties away from zero: (x + half - neg) >>> s
    logic [50:0]               w_rd;
    logic [48:0]               w_rv;
    logic signed [33:0]        r5_disp;
    logic signed [32:0]        r5_dv;
    logic signed [FIELD_W-1:0] r5_f;
    logic signed [FIELD_W-1:0] r5_vel;
    logic signed [FIELD_W-1:0] r5_pos;
    logic                      r5_act;

    assign w_rd = 51'(r4_sd)  + 51'(HALF17) - 51'(r4_sd[49]);
    assign w_rv = 49'(r4_pad) + 49'(HALF16) - 49'(r4_pad[47]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_disp <= $signed(w_rd[50:17]);
            r5_dv   <= $signed(w_rv[48:16]);
            r5_f    <= r4_f;
            r5_vel  <= r4_vel;
            r5_pos  <= r4_pos;
            r5_act  <= r4_act;
        end
    end

    // ---- final sums, saturation, pass-through for inactive bodies
    logic signed [FIELD_W-1:0] r6_pos;
    logic signed [FIELD_W-1:0] r6_vel;
    logic signed [FIELD_W-1:0] r6_acc;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_pos <= r5_act ? sat32(35'(r5_pos) + 35'(r5_disp)) : r5_pos;
            r6_vel <= r5_act ? sat32(35'(r5_vel) + 35'(r5_dv)) : r5_vel;
            r6_acc <= r5_act ? r5_f : '0;
        end
    end

    assign o_new_pos = r6_pos;
    assign o_new_vel = r6_vel;
    assign o_accel   = r6_acc;

endmodule

`default_nettype wire

>>> hw/rtl/rigid_body_motion_step.sv
// Top level: config registers, three axis lanes, valid pipeline and output register.
// Throughput: one body per cycle while not stalled; the divider resolves one quotient bit per stage,
// so its depth of 32 + FRAC_BITS stages sets most of the latency.
// The pipeline stalls only when its last stage and the output register are full and i_ready is low.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults.
`default_nettype none

module rigid_body_motion_step
    import rbms_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire t_body_in              i_body,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_body_out                  o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [FIELD_W-1:0]    i_cfg_data
);

    localparam int LAT = FIELD_W + FRAC_BITS + 7;

    // ---- configuration registers
    logic signed [FIELD_W-1:0] r_grav [3];
    logic [DT_W-1:0]           r_dt;
    logic [DT_W-1:0]           r_dtsq;
    logic [2*DT_W-1:0]         w_dt2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav[0] <= GRAV_X_RST;
            r_grav[1] <= GRAV_Y_RST;
            r_grav[2] <= GRAV_Z_RST;
            r_dt      <= DT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GRAV_X:    r_grav[0] <= $signed(i_cfg_data);
                CFG_GRAV_Y:    r_grav[1] <= $signed(i_cfg_data);
                CFG_GRAV_Z:    r_grav[2] <= $signed(i_cfg_data);
                CFG_TIME_STEP: r_dt      <= i_cfg_data[DT_W-1:0];
                default:       r_dt      <= r_dt;
            endcase
        end
    end

    // dt squared in Q0.16, rounded; stays well ahead of any item that needs it
    assign w_dt2 = (2*DT_W)'(r_dt) * (2*DT_W)'(r_dt) + (2*DT_W)'(32'h8000);

    always_ff @(posedge i_clk) begin
        r_dtsq <= w_dt2[2*DT_W-1:DT_W];
    end

    // ---- pipeline enable and valid line
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] r_act_d;
    logic [LAT-1:0] r_zm_d;
    logic           r_ov;
    logic           w_en;

    assign w_en    = !r_vld[LAT-1] || !r_ov || i_ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_act_d <= {r_act_d[LAT-2:0], i_body.active};
            r_zm_d  <= {r_zm_d[LAT-2:0], i_body.active && (i_body.mass == '0)};
        end
    end

    // ---- lanes, one per axis
    logic signed [FIELD_W-1:0] w_force [3];
    logic signed [FIELD_W-1:0] w_vel   [3];
    logic signed [FIELD_W-1:0] w_pos   [3];
    logic signed [FIELD_W-1:0] w_npos  [3];
    logic signed [FIELD_W-1:0] w_nvel  [3];
    logic signed [FIELD_W-1:0] w_acc   [3];

    assign w_force[0] = i_body.force_x;
    assign w_force[1] = i_body.force_y;
    assign w_force[2] = i_body.force_z;
    assign w_vel[0]   = i_body.vel_x;
    assign w_vel[1]   = i_body.vel_y;
    assign w_vel[2]   = i_body.vel_z;
    assign w_pos[0]   = i_body.pos_x;
    assign w_pos[1]   = i_body.pos_y;
    assign w_pos[2]   = i_body.pos_z;

    for (genvar k = 0; k < 3; k++) begin : g_lane
        rbms_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk         (i_clk),
            .i_en          (w_en),
            .i_force       (w_force[k]),
            .i_mass        (i_body.mass),
            .i_vel         (w_vel[k]),
            .i_pos         (w_pos[k]),
            .i_use_gravity (i_body.use_gravity),
            .i_active      (i_body.active),
            .i_grav        (r_grav[k]),
            .i_dt          (r_dt),
            .i_dtsq        (r_dtsq),
            .o_new_pos     (w_npos[k]),
            .o_new_vel     (w_nvel[k]),
            .o_accel       (w_acc[k])
        );
    end

    // ---- merge lanes into the output register
    t_body_out r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en && r_vld[LAT-1]) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_vld[LAT-1]) begin
            r_res.new_pos_x       <= w_npos[0];
            r_res.new_pos_y       <= w_npos[1];
            r_res.new_pos_z       <= w_npos[2];
            r_res.new_vel_x       <= w_nvel[0];
            r_res.new_vel_y       <= w_nvel[1];
            r_res.new_vel_z       <= w_nvel[2];
            r_res.accel_x         <= w_acc[0];
            r_res.accel_y         <= w_acc[1];
            r_res.accel_z         <= w_acc[2];
            r_res.updated         <= r_act_d[LAT-1];
            r_res.zero_mass_error <= r_zm_d[LAT-1];
        end
    end

    assign o_valid  = r_ov;
    assign o_result = r_res;

    // ---- assertions
    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted transfer did not enter the pipeline");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAT-1] && !w_en) |=> r_vld[LAT-1])
        else $error("stalled tail item was dropped");

    a_zm_updated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.zero_mass_error) |-> o_result.updated)
        else $error("zero mass flagged on a body that was not integrated");

    a_pass_accel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.updated) |->
        (o_result.accel_x == '0 && o_result.accel_y == '0 && o_result.accel_z == '0))
        else $error("pass-through body reports nonzero acceleration");

    a_zm_accel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.zero_mass_error) |->
        (o_result.accel_x == '0 || o_result.accel_x == S32_MAX
         || o_result.accel_x == S32_MIN))
        else $error("zero mass acceleration not saturated");

endmodule

`default_nettype wire

>>> test/rigid_body_motion_step_tb.sv
// Self-checking testbench for the rigid body motion step block.
`timescale 1ns / 1ps

module rigid_body_motion_step_tb;
    import rbms_pkg::*;

    localparam int FRAC = 16;

    // Row of the directed stimulus table
    typedef struct {
        t_body_in  body;
        bit        typed;
        t_body_out want;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    t_body_in             i_body = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    t_body_out            o_result;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_GRAV_X;
    logic [FIELD_W-1:0]   i_cfg_data = '0;

    // Our copy of the shared gravity vector and frame time
    longint         gravity_q[3] = '{longint'(GRAV_X_RST), longint'(GRAV_Y_RST),
                                     longint'(GRAV_Z_RST)};
    logic [DT_W-1:0] frame_dt = DT_RST;

    t_body_out pending_motion[$];
    t_dir_row  dir_rows[$];
    int        mismatch_count = 0;
    int        results_seen = 0;
    int        rcv_stall_pct = 0;

    rigid_body_motion_step dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_body     (i_body),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("rigid_body_motion_step_tb failed");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint clamp32(longint v);
        if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return -64'sh8000_0000;
        return v;
    endfunction

    // Divide by 2^s, nearest, ties away from zero
    function automatic longint round_away(longint x, int s);
        longint m;
        m = (x < 0) ? -x : x;
        m = (m + (longint'(1) << (s - 1))) >>> s;
        return (x < 0) ? -m : m;
    endfunction

    // Force over mass with saturation; zero mass pins a nonzero force to the rail of its sign
    function automatic longint force_over_mass(longint frc, longint m);
        longint mag;
        longint q;
        mag = (frc < 0) ? -frc : frc;
        if (m == 0) begin
            if (mag == 0) return 0;
            return (frc < 0) ? -64'sh8000_0000 : 64'sh7FFF_FFFF;
        end
        q = (mag << FRAC) / m;
        if (frc < 0) return (q > 64'sh8000_0000) ? -64'sh8000_0000 : -q;
        return (q > 64'sh7FFF_FFFF) ? 64'sh7FFF_FFFF : q;
    endfunction

    function automatic t_body_out integrate_body(t_body_in b);
        t_body_out          r;
        longint             frc[3];
        longint             vel[3];
        longint             pos[3];
        logic [FIELD_W-1:0] pos_o[3];
        logic [FIELD_W-1:0] vel_o[3];
        logic [FIELD_W-1:0] acc_o[3];
        longint             m;
        longint             f;
        longint             a;
        longint             dtl;
        longint             dtsq;
        longint             disp;
        longint             dvel;
        frc[0] = longint'($signed(b.force_x));
        frc[1] = longint'($signed(b.force_y));
        frc[2] = longint'($signed(b.force_z));
        vel[0] = longint'($signed(b.vel_x));
        vel[1] = longint'($signed(b.vel_y));
        vel[2] = longint'($signed(b.vel_z));
        pos[0] = longint'($signed(b.pos_x));
        pos[1] = longint'($signed(b.pos_y));
        pos[2] = longint'($signed(b.pos_z));
        m    = longint'({32'd0, b.mass});
        dtl  = longint'({48'd0, frame_dt});
        dtsq = (dtl * dtl + 64'sd32768) >>> 16;
        for (int k = 0; k < 3; k++) begin
            if (!b.active) begin
                pos_o[k] = 32'(pos[k]);
                vel_o[k] = 32'(vel[k]);
                acc_o[k] = '0;
            end else begin
                f    = force_over_mass(frc[k], m);
                a    = b.use_gravity ? clamp32(f + gravity_q[k]) : f;
                disp = round_away(2 * vel[k] * dtl + a * dtsq, 17);
                dvel = round_away(a * dtl, 16);
                pos_o[k] = 32'(clamp32(pos[k] + disp));
                vel_o[k] = 32'(clamp32(vel[k] + dvel));
                acc_o[k] = 32'(f);
            end
        end
        r.new_pos_x       = pos_o[0];
        r.new_pos_y       = pos_o[1];
        r.new_pos_z       = pos_o[2];
        r.new_vel_x       = vel_o[0];
        r.new_vel_y       = vel_o[1];
        r.new_vel_z       = vel_o[2];
        r.accel_x         = acc_o[0];
        r.accel_y         = acc_o[1];
        r.accel_z         = acc_o[2];
        r.updated         = b.active;
        r.zero_mass_error = b.active && (b.mass == '0);
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic t_body_in mk_body(
        logic [31:0] fx, logic [31:0] fy, logic [31:0] fz, logic [31:0] m,
        logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
        logic [31:0] px, logic [31:0] py, logic [31:0] pz,
        logic ug, logic act);
        t_body_in b;
        b = '{fx, fy, fz, m, vx, vy, vz, px, py, pz, ug, act};
        return b;
    endfunction

    function automatic t_body_out mk_motion(
        logic [31:0] px, logic [31:0] py, logic [31:0] pz,
        logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
        logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
        logic upd, logic zme);
        t_body_out r;
        r = '{px, py, pz, vx, vy, vz, ax, ay, az, upd, zme};
        return r;
    endfunction

    // Append one row to the directed table
    function automatic void add_dir_row(t_body_in b, bit typed, t_body_out want);
        t_dir_row row;
        row.body  = b;
        row.typed = typed;
        row.want  = want;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // Q16.16 value: rails, zero, full random or a modest value within +/- span
    function automatic logic [31:0] pick_q16(int unsigned span);
        case ($urandom_range(15))
            0:       return S32_MAX;
            1:       return S32_MIN;
            2:       return '0;
            3, 4, 5: return $urandom;
            default: return $urandom_range(2 * span) - span;
        endcase
    endfunction

    function automatic logic [31:0] pick_mass();
        case ($urandom_range(19))
            0:       return '0;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFF;
            3, 4:    return $urandom;
            default: return $urandom_range(32'h0000_1000, 32'h0100_0000);
        endcase
    endfunction

    function automatic t_body_in random_body();
        return mk_body(pick_q16(1 << 24), pick_q16(1 << 24), pick_q16(1 << 24),
                       pick_mass(),
                       pick_q16(1 << 22), pick_q16(1 << 22), pick_q16(1 << 22),
                       pick_q16(1 << 28), pick_q16(1 << 28), pick_q16(1 << 28),
                       1'($urandom_range(1)), ($urandom_range(9) != 0));
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string msg);
        $display("[%0t] ERROR result %0d: %s", $time, results_seen, msg);
        mismatch_count++;
    endtask

    task automatic cmp_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    task automatic check_motion(t_body_out got);
        t_body_out want;
        if (pending_motion.size() == 0) begin
            report_mismatch("result transfer with nothing pending");
        end else begin
            want = pending_motion.pop_front();
            cmp_field("new_pos_x", got.new_pos_x, want.new_pos_x);
            cmp_field("new_pos_y", got.new_pos_y, want.new_pos_y);
            cmp_field("new_pos_z", got.new_pos_z, want.new_pos_z);
            cmp_field("new_vel_x", got.new_vel_x, want.new_vel_x);
            cmp_field("new_vel_y", got.new_vel_y, want.new_vel_y);
            cmp_field("new_vel_z", got.new_vel_z, want.new_vel_z);
            cmp_field("accel_x", got.accel_x, want.accel_x);
            cmp_field("accel_y", got.accel_y, want.accel_y);
            cmp_field("accel_z", got.accel_z, want.accel_z);
            cmp_field("updated", got.updated, want.updated);
            cmp_field("zero_mass_error", got.zero_mass_error, want.zero_mass_error);
        end
        results_seen++;
    endtask

    // Result side: sample the transfer, then pick this cycle's back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            check_motion(o_result);
        end
        i_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    // ---------------------------------------------------------------- drivers

    // Offer one body, hold until transferred, then idle for a random gap
    task automatic push_body(t_body_in b, bit typed, t_body_out want, int idle_pct);
        int gap;
        gap = 0;
        i_valid <= 1'b1;
        i_body  <= b;
        do @(posedge i_clk); while (!o_ready);
        pending_motion.insert(pending_motion.size(), typed ? want : integrate_body(b));
        while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Every body yields a result, so an empty queue means the pipeline is empty
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_motion.size() != 0) @(posedge i_clk);
    endtask

    // Write all four registers on consecutive edges
    task automatic program_regs(logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                                logic [DT_W-1:0] dt);
        t_cfg_idx    idxs[4];
        logic [31:0] vals[4];
        idxs = '{CFG_GRAV_X, CFG_GRAV_Y, CFG_GRAV_Z, CFG_TIME_STEP};
        // upper bits of the time step word are junk and must be dropped
        vals = '{gx, gy, gz, {16'($urandom), dt}};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        gravity_q[0] = longint'($signed(gx));
        gravity_q[1] = longint'($signed(gy));
        gravity_q[2] = longint'($signed(gz));
        frame_dt     = dt;
    endtask

    // ---------------------------------------------------------------- main sequence

    initial begin
        logic [31:0]     ph_gx[8];
        logic [31:0]     ph_gy[8];
        logic [31:0]     ph_gz[8];
        logic [DT_W-1:0] ph_dt[8];
        int              snd_pct;
        int              rcv_pct;
        int              n_items;

        // Directed table, at reset register values
        // inactive body passes through, gravity flag ignored
        add_dir_row(mk_body(5, 6, 7, 32'h0001_0000, 32'h0002_0000, -3, 9,
                            32'h1234_5678, 32'hFFFF_0000, 0, 1, 0), 1'b1,
                    mk_motion(32'h1234_5678, 32'hFFFF_0000, 0,
                              32'h0002_0000, -3, 9, 0, 0, 0, 0, 0));
        // inactive with rails and zero mass: no error flag
        add_dir_row(mk_body(S32_MAX, S32_MIN, S32_MIN, 0, S32_MIN, S32_MAX,
                            S32_MIN, S32_MAX, S32_MIN, S32_MAX, 0, 0), 1'b1,
                    mk_motion(S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MAX,
                              S32_MIN, 0, 0, 0, 0, 0));
        // zero mass, zero force: error, nothing moves
        add_dir_row(mk_body(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1'b1,
                    mk_motion(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
        // zero mass with rail and small forces, integrated with saturated accel
        add_dir_row(mk_body(S32_MAX, S32_MIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1),
                    1'b0, '0);
        add_dir_row(mk_body(-1, 1, 0, 0, 32'h0001_8000, -32'sh0001_8000, 7,
                            100, -100, 0, 1, 1), 1'b0, '0);
        // unit mass, at rest, no gravity
        add_dir_row(mk_body(0, 0, 0, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 1),
                    1'b1, mk_motion(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
        // everything pinned high / low by the smallest mass
        add_dir_row(mk_body(S32_MAX, S32_MAX, S32_MAX, 1, S32_MAX, S32_MAX,
                            S32_MAX, S32_MAX, S32_MAX, S32_MAX, 1, 1), 1'b1,
                    mk_motion(S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX,
                              S32_MAX, S32_MAX, S32_MAX, S32_MAX, 1, 0));
        add_dir_row(mk_body(S32_MIN, S32_MIN, S32_MIN, 1, S32_MIN, S32_MIN,
                            S32_MIN, S32_MIN, S32_MIN, S32_MIN, 1, 1), 1'b1,
                    mk_motion(S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN,
                              S32_MIN, S32_MIN, S32_MIN, S32_MIN, 1, 0));
        // largest mass, unit mass at the force rails, quotient edge at -2^31
        add_dir_row(mk_body(S32_MAX, S32_MIN, 1, 32'hFFFF_FFFF, 0, 0, 0,
                            0, 0, 0, 0, 1), 1'b0, '0);
        add_dir_row(mk_body(S32_MAX, S32_MIN, -1, 32'h0001_0000, 0, 0, 0,
                            0, 0, 0, 0, 1), 1'b0, '0);
        add_dir_row(mk_body(S32_MIN, 1, -1, 32'h0001_0000, -1, 1, -3,
                            0, 0, 0, 1, 1), 1'b0, '0);
        // gravity pushing a rail acceleration further out
        add_dir_row(mk_body(0, S32_MIN, 0, 32'h0001_0000, 0, -32'sh0010_0000,
                            0, 0, S32_MIN, 0, 1, 1), 1'b0, '0);
        // alternating bit patterns
        add_dir_row(mk_body(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
                            32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                            32'hF0F0_F0F0, 32'h5555_5555, 32'hAAAA_AAAA,
                            32'h0F0F_0F0F, 1, 1), 1'b0, '0);
        add_dir_row(mk_body(32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0,
                            32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
                            32'h0F0F_0F0F, 32'hAAAA_AAAA, 32'h5555_5555,
                            32'hF0F0_F0F0, 0, 1), 1'b0, '0);
        // ordinary body, two units of mass
        add_dir_row(mk_body(32'h0004_0000, -32'sh0002_8000, 32'h0000_4000,
                            32'h0002_0000, 32'h0003_0000, -32'sh0000_8000,
                            32'h0001_0000, 32'h0100_0000, -32'sh0020_0000,
                            32'h0000_1234, 1, 1), 1'b0, '0);

        // Register settings per phase; phase 0 keeps the reset values
        ph_gx = '{GRAV_X_RST, S32_MAX, 0, $urandom_range(1 << 23) - (1 << 22),
                  S32_MIN, $urandom, GRAV_X_RST, $urandom};
        ph_gy = '{GRAV_Y_RST, S32_MIN, 0, $urandom_range(1 << 23) - (1 << 22),
                  S32_MAX, $urandom, GRAV_Y_RST, $urandom};
        ph_gz = '{GRAV_Z_RST, 0, 0, $urandom_range(1 << 23) - (1 << 22),
                  $urandom, $urandom, GRAV_Z_RST, $urandom};
        ph_dt = '{DT_RST, 16'hFFFF, 16'h0000, 16'($urandom_range(65535)),
                  16'h0001, 16'($urandom_range(65535)), DT_RST, 16'hFFFF};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            push_body(dir_rows[r].body, dir_rows[r].typed, dir_rows[r].want, 0);
        end

        // Random phases: none, sender idle, receiver stall, both
        for (int p = 0; p < 8; p++) begin
            wait_drained();
            if (p != 0) begin
                program_regs(ph_gx[p], ph_gy[p], ph_gz[p], ph_dt[p]);
            end
            snd_pct = (p % 4 == 1) ? 80 : (p % 4 == 3) ? 30 : 0;
            rcv_pct = (p % 4 == 2) ? 80 : (p % 4 == 3) ? 30 : 0;
            n_items = (p == 0) ? 130 : 140;
            for (int i = 0; i < n_items; i++) begin
                // short bursts at full rate inside every phase
                rcv_stall_pct = (i % 60 < 15) ? 0 : rcv_pct;
                push_body(random_body(), 1'b0, '0, (i % 60 < 15) ? 0 : snd_pct);
            end
        end

        rcv_stall_pct = 0;
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("rigid_body_motion_step_tb passed");
        end else begin
            $display("rigid_body_motion_step_tb failed");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/rbms_pkg.sv
hw/rtl/rbms_div.sv
hw/rtl/rbms_lane.sv
hw/rtl/rigid_body_motion_step.sv
test/rigid_body_motion_step_tb.sv
